// ===== rtl/dss_pkg.sv =====
// Shared types, constants and the control store of the drum step sequencer.
// Depends on nothing; every other file imports it.
package dss_pkg;

    // Pattern store geometry.
    localparam int MAX_STEPS      = 64;
    localparam int SLOTS_PER_STEP = 5;
    localparam int DRUM_SLOTS     = 4;
    localparam int STORE_SIZE     = MAX_STEPS * SLOTS_PER_STEP;
    localparam int STORE_AW       = $clog2(STORE_SIZE);
    localparam int TRACK_W        = $clog2(SLOTS_PER_STEP);

    // Field widths fixed by the interface.
    localparam int TICK_W  = 16;
    localparam int SLOT_W  = 10;
    localparam int ADDR_W  = 9;
    localparam int NOTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int BEATS_W = 8;
    localparam int CLICK_W = 7;
    localparam int MODE_W  = 2;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 16;

    // Remainder unit widths: the divisor can be a step length plus remainder.
    localparam int DVD_W  = TICK_W;
    localparam int DVS_W  = TICK_W + 1;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_BAR_LEN   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_STEP_LEN  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_STEP_REM  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_BEATS     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_METRO_EN  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_RUN_MODE  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_CLICK     = 3'd6;

    // Run modes.
    localparam logic [MODE_W-1:0] MODE_STARTED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    // Event kinds.
    localparam logic [KIND_W-1:0] EV_DRUM  = 2'd0;
    localparam logic [KIND_W-1:0] EV_BASS  = 2'd1;
    localparam logic [KIND_W-1:0] EV_CLICK = 2'd2;
    localparam logic [KIND_W-1:0] EV_BAR   = 2'd3;

    // Request types.
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Datapath operations of one control word.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT    = 4'd1;
    localparam logic [OP_W-1:0] OP_WRITE     = 4'd2;
    localparam logic [OP_W-1:0] OP_MOD_TICK  = 4'd3;
    localparam logic [OP_W-1:0] OP_MOD_SLOT  = 4'd4;
    localparam logic [OP_W-1:0] OP_CLICK     = 4'd5;
    localparam logic [OP_W-1:0] OP_SLOT_CLR  = 4'd6;
    localparam logic [OP_W-1:0] OP_READ      = 4'd7;
    localparam logic [OP_W-1:0] OP_SLOT_EMIT = 4'd8;
    localparam logic [OP_W-1:0] OP_SLOT_ADV  = 4'd9;
    localparam logic [OP_W-1:0] OP_TICK_INC  = 4'd10;
    localparam logic [OP_W-1:0] OP_FLUSH     = 4'd11;
    localparam logic [OP_W-1:0] OP_BAR       = 4'd12;

    // Jump conditions of one control word.
    localparam int COND_W = 4;
    localparam logic [COND_W-1:0] C_NEVER       = 4'd0;
    localparam logic [COND_W-1:0] C_ALWAYS      = 4'd1;
    localparam logic [COND_W-1:0] C_NO_IN       = 4'd2;
    localparam logic [COND_W-1:0] C_IS_TICK     = 4'd3;
    localparam logic [COND_W-1:0] C_STOPPED     = 4'd4;
    localparam logic [COND_W-1:0] C_BAR_END     = 4'd5;
    localparam logic [COND_W-1:0] C_DIV_BUSY    = 4'd6;
    localparam logic [COND_W-1:0] C_NO_STEP     = 4'd7;
    localparam logic [COND_W-1:0] C_NOT_STARTED = 4'd8;
    localparam logic [COND_W-1:0] C_MORE_SLOTS  = 4'd9;

    // Program addresses.
    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] L_IDLE     = 5'd0;
    localparam logic [UPC_W-1:0] L_DECODE   = 5'd1;
    localparam logic [UPC_W-1:0] L_WRITE    = 5'd2;
    localparam logic [UPC_W-1:0] L_TICK     = 5'd3;
    localparam logic [UPC_W-1:0] L_BAR_TEST = 5'd4;
    localparam logic [UPC_W-1:0] L_MOD_TICK = 5'd5;
    localparam logic [UPC_W-1:0] L_WAIT_T   = 5'd6;
    localparam logic [UPC_W-1:0] L_STEP_T   = 5'd7;
    localparam logic [UPC_W-1:0] L_MOD_SLOT = 5'd8;
    localparam logic [UPC_W-1:0] L_WAIT_S   = 5'd9;
    localparam logic [UPC_W-1:0] L_CLICK    = 5'd10;
    localparam logic [UPC_W-1:0] L_SLOT_CLR = 5'd11;
    localparam logic [UPC_W-1:0] L_READ     = 5'd12;
    localparam logic [UPC_W-1:0] L_EMIT     = 5'd13;
    localparam logic [UPC_W-1:0] L_ADV      = 5'd14;
    localparam logic [UPC_W-1:0] L_TICK_INC = 5'd15;
    localparam logic [UPC_W-1:0] L_FLUSH    = 5'd16;
    localparam logic [UPC_W-1:0] L_BAR      = 5'd17;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [UPC_W-1:0]  target;
    } ucode_t;

    // Status flags the datapath hands to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic is_tick;
        logic run_active;
        logic bar_end;
        logic div_busy;
        logic no_step;
        logic started;
        logic more_slots;
        logic stall;
    } seq_flags_t;

    // The control program: one word per program address.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            L_IDLE:     w = '{op: OP_ACCEPT,    cond: C_NO_IN,       target: L_IDLE};
            L_DECODE:   w = '{op: OP_NOP,       cond: C_IS_TICK,     target: L_TICK};
            L_WRITE:    w = '{op: OP_WRITE,     cond: C_ALWAYS,      target: L_IDLE};
            L_TICK:     w = '{op: OP_NOP,       cond: C_STOPPED,     target: L_IDLE};
            L_BAR_TEST: w = '{op: OP_NOP,       cond: C_BAR_END,     target: L_BAR};
            L_MOD_TICK: w = '{op: OP_MOD_TICK,  cond: C_NEVER,       target: L_IDLE};
            L_WAIT_T:   w = '{op: OP_NOP,       cond: C_DIV_BUSY,    target: L_WAIT_T};
            L_STEP_T:   w = '{op: OP_NOP,       cond: C_NO_STEP,     target: L_TICK_INC};
            L_MOD_SLOT: w = '{op: OP_MOD_SLOT,  cond: C_NEVER,       target: L_IDLE};
            L_WAIT_S:   w = '{op: OP_NOP,       cond: C_DIV_BUSY,    target: L_WAIT_S};
            L_CLICK:    w = '{op: OP_CLICK,     cond: C_NOT_STARTED, target: L_ADV};
            L_SLOT_CLR: w = '{op: OP_SLOT_CLR,  cond: C_NEVER,       target: L_IDLE};
            L_READ:     w = '{op: OP_READ,      cond: C_NEVER,       target: L_IDLE};
            L_EMIT:     w = '{op: OP_SLOT_EMIT, cond: C_MORE_SLOTS,  target: L_READ};
            L_ADV:      w = '{op: OP_SLOT_ADV,  cond: C_NEVER,       target: L_IDLE};
            L_TICK_INC: w = '{op: OP_TICK_INC,  cond: C_NEVER,       target: L_IDLE};
            L_FLUSH:    w = '{op: OP_FLUSH,     cond: C_ALWAYS,      target: L_IDLE};
            L_BAR:      w = '{op: OP_BAR,       cond: C_ALWAYS,      target: L_FLUSH};
            default:    w = '{op: OP_NOP,       cond: C_ALWAYS,      target: L_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/dss_rem.sv =====
// Iterative remainder unit: one restoring step per cycle, dividend MSB first.
// Depends on dss_pkg for its widths.
module dss_rem
    import dss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             rem_zero
);

    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    // Step counter; the unit is busy until every dividend bit is in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DCNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Partial remainder and dividend shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= diff[DVS_W-1:0];
            end
            else
            begin
                rem_reg <= trial[DVS_W-1:0];
            end
        end
    end

    assign busy     = (cnt_reg != '0);
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/dss_useq.sv =====
// Microprogram sequencer: program counter, control store and jump logic.
// Depends on dss_pkg for the control word format and the program itself.
module dss_useq
    import dss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ucode_t     uword
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             taken;

    assign uword = ucode_rom(upc_reg);

    // Evaluate the jump condition of the current word.
    always_comb
    begin
        unique case (uword.cond)
            C_NEVER:       taken = 1'b0;
            C_ALWAYS:      taken = 1'b1;
            C_NO_IN:       taken = !flags.in_valid;
            C_IS_TICK:     taken = flags.is_tick;
            C_STOPPED:     taken = !flags.run_active;
            C_BAR_END:     taken = flags.bar_end;
            C_DIV_BUSY:    taken = flags.div_busy;
            C_NO_STEP:     taken = flags.no_step;
            C_NOT_STARTED: taken = !flags.started;
            C_MORE_SLOTS:  taken = flags.more_slots;
            default:       taken = 1'b1;
        endcase
    end

    // A stall holds the current word until the output side has room.
    always_comb
    begin
        if (flags.stall)
        begin
            upc_next = upc_reg;
        end
        else if (taken)
        begin
            upc_next = uword.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= L_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/drum_step_sequencer_tick.sv =====
// Top level of the drum step sequencer: configuration, counters, pattern store
// and event output. Depends on dss_pkg, dss_rem and dss_useq.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  input     s_tvalid/s_tready    s_tuser: req_type; s_tdata: addr, note
//  output    m_tvalid/m_tready    m_tuser: event_kind; m_tdata: note; m_tlast
//  config    cfg_valid/cfg_ready  cfg_index: register; cfg_data: value
//
// A microprogram walks each word. Each remainder takes the start word, then a
// wait word that repeats while the bit-serial unit shifts, until it finds the
// unit idle. Each of the five pattern slots passes through the store read port.
// Reset clears control state; the pattern store is not cleared. An emitting
// word (click, slot or flush) stalls while the lookahead event and the output
// register are both full and the receiver is not ready.
module drum_step_sequencer_tick
    import dss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,     // slot_address[8:0], slot_note[16:9], zeros
    input  logic              s_tuser,     // req_type
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,     // note_value[7:0]
    output logic [KIND_W-1:0] m_tuser,     // event_kind[1:0]
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    // Configuration registers.
    logic [TICK_W-1:0]  bar_len_reg;
    logic [TICK_W-1:0]  step_len_reg;
    logic [TICK_W-1:0]  step_rem_reg;
    logic [BEATS_W-1:0] beats_reg;
    logic               metro_en_reg;
    logic [MODE_W-1:0]  run_mode_reg;
    logic [CLICK_W-1:0] click_reg;

    // Latched input word.
    logic               in_type_reg;
    logic [ADDR_W-1:0]  in_addr_reg;
    logic [NOTE_W-1:0]  in_note_reg;

    // Sequencer state.
    logic [TICK_W-1:0]  tick_count_reg;
    logic [SLOT_W-1:0]  slot_index_reg;
    logic [TRACK_W-1:0] track_reg;

    // Pattern store and its read side.
    logic [NOTE_W-1:0]  store_mem [STORE_SIZE];
    logic [NOTE_W-1:0]  rd_data_reg;
    logic               rd_hit_reg;
    logic [SLOT_W:0]    rd_full;
    logic               rd_in_range;

    // One event of lookahead so the final event of a word can be flagged.
    logic               pend_valid_reg;
    logic [KIND_W-1:0]  pend_kind_reg;
    logic [NOTE_W-1:0]  pend_note_reg;

    // Output register.
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [NOTE_W-1:0]  out_note_reg;
    logic               out_last_reg;

    ucode_t             uword;
    seq_flags_t         flags;
    logic               exec;
    logic               needs_out;
    logic               stall;
    logic [DVS_W-1:0]   step_len;
    logic               div_start;
    logic [DVD_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic               div_busy;
    logic               div_zero;
    logic               click_fire;
    logic               slot_fire;
    logic [KIND_W-1:0]  slot_kind;
    logic               new_valid;
    logic [KIND_W-1:0]  new_kind;
    logic [NOTE_W-1:0]  new_note;
    logic               out_load;
    logic [KIND_W-1:0]  out_kind_d;
    logic [NOTE_W-1:0]  out_note_d;
    logic               out_last_d;
    logic               run_active;

    assign cfg_ready = 1'b1;
    assign s_tready  = (uword.op == OP_ACCEPT);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_len_reg  <= '0;
            step_len_reg <= TICK_W'(1);
            step_rem_reg <= '0;
            beats_reg    <= BEATS_W'(4);
            metro_en_reg <= 1'b0;
            run_mode_reg <= '0;
            click_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BAR_LEN:  bar_len_reg  <= cfg_data;
                REG_STEP_LEN: step_len_reg <= cfg_data;
                REG_STEP_REM: step_rem_reg <= cfg_data;
                REG_BEATS:    beats_reg    <= cfg_data[BEATS_W-1:0];
                REG_METRO_EN: metro_en_reg <= cfg_data[0];
                REG_RUN_MODE: run_mode_reg <= cfg_data[MODE_W-1:0];
                REG_CLICK:    click_reg    <= cfg_data[CLICK_W-1:0];
                default:      ;
            endcase
        end
    end

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_type_reg <= s_tuser;
            in_addr_reg <= s_tdata[ADDR_W-1:0];
            in_note_reg <= s_tdata[ADDR_W+NOTE_W-1:ADDR_W];
        end
    end

    // Step length, stretched by the remainder at the second step.
    always_comb
    begin
        step_len = {1'b0, step_len_reg};
        if ((step_rem_reg != '0) && (slot_index_reg == SLOT_W'(SLOTS_PER_STEP)))
        begin
            step_len = {1'b0, step_len_reg} + {1'b0, step_rem_reg};
        end
    end

    // Remainder unit operands.
    assign div_start    = exec && ((uword.op == OP_MOD_TICK) || (uword.op == OP_MOD_SLOT));
    assign div_dividend = (uword.op == OP_MOD_TICK) ? tick_count_reg
                                                    : DVD_W'(slot_index_reg);
    assign div_divisor  = (uword.op == OP_MOD_TICK) ? step_len : DVS_W'(beats_reg);

    dss_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .rem_zero (div_zero)
    );

    // Flags for the sequencer.
    assign run_active = (run_mode_reg == MODE_STARTED) || (run_mode_reg == MODE_PAUSED);

    always_comb
    begin
        flags.in_valid   = s_tvalid;
        flags.is_tick    = (in_type_reg == REQ_TICK);
        flags.run_active = run_active;
        flags.bar_end    = !(tick_count_reg < bar_len_reg);
        flags.div_busy   = div_busy;
        flags.no_step    = (step_len == '0) || !div_zero;
        flags.started    = (run_mode_reg == MODE_STARTED);
        flags.more_slots = (track_reg < TRACK_W'(DRUM_SLOTS));
        flags.stall      = stall;
    end

    dss_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .uword (uword)
    );

    // Events a word may produce this cycle.
    assign click_fire = metro_en_reg && (beats_reg != '0) && div_zero;
    assign slot_fire  = rd_hit_reg && (rd_data_reg != '0);
    assign slot_kind  = (track_reg == TRACK_W'(DRUM_SLOTS)) ? EV_BASS : EV_DRUM;

    // Hold the word when pushing the lookahead event would overrun the output.
    assign needs_out = (uword.op == OP_CLICK) || (uword.op == OP_SLOT_EMIT) ||
                       (uword.op == OP_FLUSH);
    assign stall     = needs_out && pend_valid_reg && out_valid_reg && !m_tready;
    assign exec      = !stall;

    always_comb
    begin
        new_valid = 1'b0;
        new_kind  = EV_DRUM;
        new_note  = '0;
        if (exec && (uword.op == OP_CLICK) && click_fire)
        begin
            new_valid = 1'b1;
            new_kind  = EV_CLICK;
            new_note  = NOTE_W'(click_reg);
        end
        else if (exec && (uword.op == OP_SLOT_EMIT) && slot_fire)
        begin
            new_valid = 1'b1;
            new_kind  = slot_kind;
            new_note  = rd_data_reg;
        end
    end

    // The lookahead event moves to the output when a newer one arrives or at flush.
    always_comb
    begin
        out_load   = pend_valid_reg &&
                     (new_valid || (exec && (uword.op == OP_FLUSH)));
        out_kind_d = pend_kind_reg;
        out_note_d = pend_note_reg;
        out_last_d = !new_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (new_valid)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (exec && (uword.op == OP_BAR))
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (exec && (uword.op == OP_FLUSH))
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (new_valid)
        begin
            pend_kind_reg <= new_kind;
            pend_note_reg <= new_note;
        end
        else if (exec && (uword.op == OP_BAR))
        begin
            pend_kind_reg <= EV_BAR;
            pend_note_reg <= '0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg <= out_kind_d;
            out_note_reg <= out_note_d;
            out_last_reg <= out_last_d;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_note_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Tick and slot counters, and the track counter of the slot loop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            slot_index_reg <= '0;
            track_reg      <= '0;
        end
        else if (exec)
        begin
            case (uword.op)
                OP_TICK_INC:  tick_count_reg <= tick_count_reg + 1'b1;
                OP_SLOT_ADV:  slot_index_reg <= slot_index_reg + SLOT_W'(SLOTS_PER_STEP);
                OP_SLOT_CLR:  track_reg      <= '0;
                OP_SLOT_EMIT: track_reg      <= track_reg + 1'b1;
                OP_BAR:
                begin
                    tick_count_reg <= '0;
                    slot_index_reg <= '0;
                end
                default:      ;
            endcase
        end
    end

    // Pattern store: one write port, one registered read port.
    assign rd_full     = {1'b0, slot_index_reg} + (SLOT_W + 1)'(track_reg);
    assign rd_in_range = (rd_full < (SLOT_W + 1)'(STORE_SIZE));

    always_ff @(posedge clk)
    begin
        if (exec && (uword.op == OP_WRITE) &&
            ({1'b0, in_addr_reg} < (ADDR_W + 1)'(STORE_SIZE)))
        begin
            store_mem[STORE_AW'(in_addr_reg)] <= in_note_reg;
        end
        if (exec && (uword.op == OP_READ))
        begin
            rd_hit_reg <= rd_in_range;
            if (rd_in_range)
            begin
                rd_data_reg <= store_mem[STORE_AW'(rd_full)];
            end
        end
    end

endmodule
